>>> rtl/abad_pkg.sv
// Shared types and constants for the adaptive binary arithmetic decoder.
package abad_pkg;

    localparam int CONTEXT_BITS = 8;
    localparam int CTX_DEPTH    = 1 << CONTEXT_BITS;
    localparam int COUNT_W      = 28;
    localparam int ENTRY_W      = 2 * COUNT_W;
    localparam int DEN_W        = COUNT_W + 2;
    localparam int QUOT_W       = 32;
    localparam int QCNT_W       = $clog2(QUOT_W);

    localparam logic [COUNT_W:0] COUNT_LIMIT = (COUNT_W + 1)'(32'h0FFF_FFFF);

    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    localparam logic [3:0] RESET_PENDING = 4'd8;

    typedef struct packed {
        logic       op;
        logic [7:0] code_byte;
    } req_t;

    typedef struct packed {
        logic       decoded_bit;
        logic [3:0] bytes_needed;
        logic       status;
    } rsp_t;

    typedef struct packed {
        logic [COUNT_W-1:0] c1;
        logic [COUNT_W-1:0] c0;
    } pair_t;

endpackage

>>> rtl/adaptive_binary_arith_decoder_unit.sv
// Top level: byte intake, interval split, context update and renormalization.
// Byte item: result registered on acceptance; one item per cycle while rsp_stall does
// not hold a result. Decode item: split, update, renormalization (0..8 byte shifts),
// read, load and the bit-serial probability divider; no item is taken meanwhile.
// Reset: interval full, code zero, probability all ones, 8 bytes owed; the context
// table is cleared at once through per-entry valid bits.
module adaptive_binary_arith_decoder_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  abad_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output abad_pkg::rsp_t  rsp
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SPLIT = 7'b0000010,
        S_UPD   = 7'b0000100,
        S_NORM  = 7'b0001000,
        S_RD    = 7'b0010000,
        S_LOAD  = 7'b0100000,
        S_DIV   = 7'b1000000
    } state_t;

    localparam int CB = abad_pkg::CONTEXT_BITS;
    localparam int CW = abad_pkg::COUNT_W;

    state_t                 state_reg, state_next;
    logic [63:0]            low_reg;
    logic [63:0]            high_reg;
    logic [63:0]            code_reg;
    logic [63:0]            prod_reg;
    logic [63:0]            split_reg;
    logic                   bit_reg;
    logic [CB-1:0]          hist_reg;
    logic [31:0]            prob_reg;
    logic [3:0]             pend_reg;
    logic [3:0]             norm_reg;
    logic                   rsp_valid_reg;
    abad_pkg::rsp_t         rsp_reg;

    logic                   accept;
    logic                   take;
    logic                   rsp_load;
    logic [63:0]            diff;
    logic [63:0]            split;
    logic                   top_same;

    logic                   ram_rd_en;
    logic [CB-1:0]          ram_rd_addr;
    abad_pkg::pair_t        ram_rd_data;
    logic                   ram_wr_en;
    abad_pkg::pair_t        ram_wr_data;

    logic [CW:0]            inc;
    logic [CW:0]            c0_new;
    logic [CW:0]            c1_new;

    logic                   div_start;
    logic [CW:0]            div_num;
    logic [abad_pkg::DEN_W-1:0] div_den;
    logic                   div_done;
    logic [31:0]            div_quot;

    assign req_stall = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;
    assign take      = rsp_valid_reg && !rsp_stall;
    assign rsp_load  = (accept && (req.op == abad_pkg::OP_BYTE || pend_reg != 4'd0))
                       || (state_reg == S_DIV && div_done);
    assign diff      = high_reg - low_reg;
    assign split     = low_reg + prod_reg;
    assign top_same  = (low_reg[63:56] == high_reg[63:56]);

    assign ram_rd_en   = (accept && req.op == abad_pkg::OP_DECODE && pend_reg == 4'd0)
                         || (state_reg == S_RD);
    assign ram_rd_addr = hist_reg;
    assign ram_wr_en   = (state_reg == S_UPD);

    always_comb
    begin
        inc    = bit_reg ? ({1'b0, ram_rd_data.c1} + 1'b1) : ({1'b0, ram_rd_data.c0} + 1'b1);
        c0_new = bit_reg ? {1'b0, ram_rd_data.c0} : inc;
        c1_new = bit_reg ? inc : {1'b0, ram_rd_data.c1};
        if (inc > abad_pkg::COUNT_LIMIT)
        begin
            c0_new = c0_new >> 1;
            c1_new = c1_new >> 1;
        end
        ram_wr_data.c0 = c0_new[CW-1:0];
        ram_wr_data.c1 = c1_new[CW-1:0];
    end

    assign div_start = (state_reg == S_LOAD);
    assign div_num   = {1'b0, ram_rd_data.c1} + 1'b1;
    assign div_den   = abad_pkg::DEN_W'({2'b00, ram_rd_data.c0})
                       + abad_pkg::DEN_W'({2'b00, ram_rd_data.c1}) + 2'd2;

    abad_ctx_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (hist_reg),
        .wr_data (ram_wr_data)
    );

    abad_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && req.op == abad_pkg::OP_DECODE && pend_reg == 4'd0)
                begin
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT: state_next = S_UPD;
            S_UPD:   state_next = S_NORM;
            S_NORM:
            begin
                if (!(top_same && norm_reg != 4'd8))
                begin
                    state_next = S_RD;
                end
            end
            S_RD:    state_next = S_LOAD;
            S_LOAD:  state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg <= {32'd0, diff[63:32]} * {32'd0, prob_reg};
        end
        if (state_reg == S_SPLIT)
        begin
            split_reg <= split;
            bit_reg   <= (code_reg <= split);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            low_reg       <= '0;
            high_reg      <= '1;
            code_reg      <= '0;
            hist_reg      <= '0;
            prob_reg      <= '1;
            pend_reg      <= abad_pkg::RESET_PENDING;
            norm_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (req.op == abad_pkg::OP_BYTE)
                        begin
                            rsp_reg.decoded_bit <= 1'b0;
                            if (pend_reg == 4'd0)
                            begin
                                rsp_reg.bytes_needed <= pend_reg;
                                rsp_reg.status       <= abad_pkg::STATUS_REJECT;
                            end
                            else
                            begin
                                code_reg             <= {code_reg[55:0], req.code_byte};
                                pend_reg             <= pend_reg - 1'b1;
                                rsp_reg.bytes_needed <= pend_reg - 1'b1;
                                rsp_reg.status       <= abad_pkg::STATUS_OK;
                            end
                        end
                        else if (pend_reg != 4'd0)
                        begin
                            rsp_reg.decoded_bit  <= 1'b0;
                            rsp_reg.bytes_needed <= pend_reg;
                            rsp_reg.status       <= abad_pkg::STATUS_REJECT;
                        end
                    end
                end
                S_UPD:
                begin
                    if (bit_reg)
                    begin
                        high_reg <= split_reg;
                    end
                    else
                    begin
                        low_reg <= split_reg + 1'b1;
                    end
                    hist_reg <= {hist_reg[CB-2:0], bit_reg};
                    norm_reg <= '0;
                end
                S_NORM:
                begin
                    if (top_same && norm_reg != 4'd8)
                    begin
                        low_reg  <= {low_reg[55:0], 8'h00};
                        high_reg <= {high_reg[55:0], 8'hFF};
                        pend_reg <= pend_reg + 1'b1;
                        norm_reg <= norm_reg + 1'b1;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        prob_reg             <= div_quot;
                        rsp_reg.decoded_bit  <= bit_reg;
                        rsp_reg.bytes_needed <= pend_reg;
                        rsp_reg.status       <= abad_pkg::STATUS_OK;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 4'd8)
        else $error("owed byte count out of range");

    a_reject_no_bit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status == abad_pkg::STATUS_REJECT |-> !rsp_reg.decoded_bit)
        else $error("rejected transaction carries a bit");

    a_split_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SPLIT |-> $past(state_reg == S_IDLE) && $past(pend_reg == 4'd0))
        else $error("decode started with bytes owed");

    a_done_free_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && div_done |-> !rsp_valid_reg || !rsp_stall)
        else $error("result register busy at decode completion");

endmodule

>>> rtl/abad_ctx_ram.sv
// Context pair-count memory with per-entry valid bits cleared at reset.
module abad_ctx_ram (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               rd_en,
    input  logic [abad_pkg::CONTEXT_BITS-1:0]  rd_addr,
    output abad_pkg::pair_t                    rd_data,
    input  logic                               wr_en,
    input  logic [abad_pkg::CONTEXT_BITS-1:0]  wr_addr,
    input  abad_pkg::pair_t                    wr_data
);

    abad_pkg::pair_t                    mem [abad_pkg::CTX_DEPTH];
    logic [abad_pkg::CTX_DEPTH-1:0]     valid_reg;
    abad_pkg::pair_t                    q_reg;
    logic                               q_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                q_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = q_valid_reg ? q_reg : '0;

endmodule

>>> rtl/abad_div.sv
// Restoring divider producing the 32-bit probability quotient one bit per cycle.
module abad_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [abad_pkg::COUNT_W:0]         num,
    input  logic [abad_pkg::DEN_W-1:0]         den,
    output logic                               done,
    output logic [abad_pkg::QUOT_W-1:0]        quot
);

    logic [abad_pkg::DEN_W-1:0]   rem_reg;
    logic [abad_pkg::DEN_W-1:0]   den_reg;
    logic [abad_pkg::QUOT_W-1:0]  quot_reg;
    logic [abad_pkg::QCNT_W-1:0]  cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [abad_pkg::DEN_W:0]     shifted;
    logic                         fits;

    assign shifted = {rem_reg, 1'b0};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= abad_pkg::DEN_W'(num);
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= abad_pkg::DEN_W'(shifted - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= shifted[abad_pkg::DEN_W-1:0];
            end
            quot_reg <= {quot_reg[abad_pkg::QUOT_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '1);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < den_reg)
        else $error("divider remainder not below divisor");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without work");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start)
        else $error("divider restarted while busy");

endmodule

>>> dv/abad_checker.sv
// Checker for the adaptive binary arithmetic decoder: predicts results and compares them.
`timescale 1ns / 1ps
module abad_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_stall,
    input  abad_pkg::req_t  req,
    input  logic            rsp_valid,
    input  logic            rsp_stall,
    input  abad_pkg::rsp_t  rsp,
    output int              fail_count,
    output int              pending_count
);

    logic [63:0]    lo_q;
    logic [63:0]    hi_q;
    logic [63:0]    code_q;
    logic [7:0]     hist_q;
    logic [31:0]    prob_q;
    logic [27:0]    cnt0 [abad_pkg::CTX_DEPTH];
    logic [27:0]    cnt1 [abad_pkg::CTX_DEPTH];
    logic [3:0]     owed_q;
    abad_pkg::rsp_t expected_q [$];

    function automatic void reset_decoder();
        lo_q   = '0;
        hi_q   = '1;
        code_q = '0;
        hist_q = '0;
        prob_q = 32'hFFFF_FFFF;
        owed_q = abad_pkg::RESET_PENDING;
        for (int i = 0; i < abad_pkg::CTX_DEPTH; i++)
        begin
            cnt0[i] = '0;
            cnt1[i] = '0;
        end
    endfunction

    function automatic abad_pkg::rsp_t decode_item(abad_pkg::req_t r);
        abad_pkg::rsp_t o;
        logic [63:0]    split;
        logic [28:0]    bumped;
        logic [63:0]    num;
        logic [63:0]    den;
        logic [7:0]     ctx;
        o = '0;
        o.status = abad_pkg::STATUS_OK;
        if (r.op == abad_pkg::OP_BYTE)
        begin
            if (owed_q == 4'd0)
                o.status = abad_pkg::STATUS_REJECT;
            else
            begin
                code_q = {code_q[55:0], r.code_byte};
                owed_q = owed_q - 4'd1;
            end
        end
        else if (owed_q != 4'd0)
            o.status = abad_pkg::STATUS_REJECT;
        else
        begin
            split = lo_q + (((hi_q - lo_q) >> 32) * {32'd0, prob_q});
            o.decoded_bit = (code_q <= split);
            if (o.decoded_bit)
                hi_q = split;
            else
                lo_q = split + 64'd1;
            ctx = hist_q;
            bumped = (o.decoded_bit ? {1'b0, cnt1[ctx]} : {1'b0, cnt0[ctx]}) + 29'd1;
            if (o.decoded_bit)
                cnt1[ctx] = bumped[27:0];
            else
                cnt0[ctx] = bumped[27:0];
            if (bumped > 29'h0FFF_FFFF)
            begin
                if (o.decoded_bit)
                    cnt1[ctx] = bumped[28:1];
                else
                    cnt0[ctx] = bumped[28:1];
                if (o.decoded_bit)
                    cnt0[ctx] = cnt0[ctx] >> 1;
                else
                    cnt1[ctx] = cnt1[ctx] >> 1;
            end
            hist_q = {hist_q[6:0], o.decoded_bit};
            num = ({32'd0, 4'd0, cnt1[hist_q]} + 64'd1) << 32;
            den = {36'd0, cnt0[hist_q]} + {36'd0, cnt1[hist_q]} + 64'd2;
            prob_q = 32'(num / den);
            for (int n = 0; n < 8; n++)
            begin
                if (((lo_q ^ hi_q) & 64'hFF00_0000_0000_0000) != 64'd0)
                    break;
                lo_q = lo_q << 8;
                hi_q = {hi_q[55:0], 8'hFF};
                owed_q = owed_q + 4'd1;
            end
        end
        o.bytes_needed = owed_q;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        abad_pkg::rsp_t want;
        if (!rst_n)
        begin
            reset_decoder();
            expected_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected transaction: %p", rsp);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.decoded_bit !== want.decoded_bit)
                    begin
                        $error("decoded_bit exp %0d got %0d", want.decoded_bit, rsp.decoded_bit);
                        fail_count++;
                    end
                    if (rsp.bytes_needed !== want.bytes_needed)
                    begin
                        $error("bytes_needed exp %0d got %0d", want.bytes_needed,
                               rsp.bytes_needed);
                        fail_count++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status exp %0d got %0d", want.status, rsp.status);
                        fail_count++;
                    end
                end
            end
            if (req_valid && !req_stall)
                expected_q.push_back(decode_item(req));
        end
        pending_count = expected_q.size();
    end
endmodule

>>> dv/tb_adaptive_binary_arith_decoder_unit.sv
// Testbench top: stimulus for the adaptive binary arithmetic decoder and the verdict.
`timescale 1ns / 1ps
module tb_adaptive_binary_arith_decoder_unit;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    abad_pkg::req_t req = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b1;
    abad_pkg::rsp_t rsp;
    int             fail_count;
    int             pending_count;
    int             cycles = 0;
    bit             hold_on = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    adaptive_binary_arith_decoder_unit dut (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_stall(req_stall),
        .req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    abad_checker checker_i (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_stall(req_stall),
        .req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2_500_000)
        begin
            $display("tb_adaptive_binary_arith_decoder_unit: done, errors");
            $finish;
        end
    end

    task automatic send_item(logic op, logic [7:0] b);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= '{op: op, code_byte: b};
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int r;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        send_item(abad_pkg::OP_DECODE, 8'h00);
        send_item(abad_pkg::OP_BYTE, 8'hFF);
        for (int i = 0; i < 7; i++)
            send_item(abad_pkg::OP_BYTE, (i % 2) ? 8'hFF : 8'h00);
        send_item(abad_pkg::OP_BYTE, 8'hAA);
        for (int i = 0; i < 10; i++)
            send_item(abad_pkg::OP_DECODE, 8'h55);
        send_item(abad_pkg::OP_BYTE, 8'h55);
        hold_on = 1'b1;
        for (int i = 0; i < 1350; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                send_item(1'($urandom), 8'($urandom));
            else if (r < 55)
                send_item(abad_pkg::OP_DECODE, 8'($urandom));
            else
                send_item(abad_pkg::OP_BYTE, 8'($urandom));
        end
        req_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("tb_adaptive_binary_arith_decoder_unit: done, clean");
        else
            $display("tb_adaptive_binary_arith_decoder_unit: done, errors");
        $finish;
    end

    initial
    begin
        int gap;
        wait (rst_n);
        @(negedge clk);
        rsp_stall <= 1'b0;
        wait (hold_on);
        @(negedge clk);
        rsp_stall <= 1'b1;
        repeat (300) @(negedge clk);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (gap != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end
endmodule
